/* rtl/ffha_pkg.sv */
// Shared constants for the first-fit heap allocator: field widths, stream packing,
// operation and status codes, reset values and parameter defaults.
// No dependencies.
`default_nettype none
package ffha_pkg;
	localparam int ADDR_BITS = 32;
	localparam int ALIGN_BITS = 13;
	localparam int CNT_OUT_BITS = 7;
	localparam int MAX_BLOCKS_DEF = 64;
	localparam int HEADER_BYTES_DEF = 8;
	localparam int MARKER_BYTES_DEF = 16;

	localparam int S_DATA_BITS = 72;   // 65 bits of fields, zero filled
	localparam int M_DATA_BITS = 104;  // 103 bits of fields, zero filled

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_PLANT = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [1:0] REG_HEAP_START = 2'd0;
	localparam logic [1:0] REG_HEAP_END = 2'd1;
	localparam logic [1:0] REG_ALIGN = 2'd2;

	localparam logic [ADDR_BITS-1:0] HEAP_START_RST = 32'd0;
	localparam logic [ADDR_BITS-1:0] HEAP_END_RST = 32'd65536;
	localparam logic [ALIGN_BITS-1:0] ALIGN_RST = 13'd8;
endpackage
`default_nettype wire

/* rtl/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator: request sequencer, marker and
// counter registers, result register. Uses ffha_pkg, ffha_mod_unit, ffha_node_mem.
//
//  channel   | signals                              | direction
//  ----------+--------------------------------------+----------
//  s_axis    | tvalid tready tdata tuser            | request in
//  m_axis    | tvalid tready tdata tuser            | result out
//  cfg       | valid ready index data               | register write
//
// An allocate passes the size through the remainder unit, pops a recycled node if one is
// free and walks the list one node read at a time; a header overflow, a rounding overflow
// or a full table ends it early. A release walks its list to the matching block; plant
// takes the marker registers or reads the last node; an unknown op goes straight to done.
// A register write rebuilds the heap; no clearing pass.
// Reset is asynchronous; it sets the heap to its default layout at once.
// A new request is taken while the previous result waits in the output register.
`default_nettype none
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int MARKER_BYTES = MARKER_BYTES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// request_size[31:0], force_kernel[32], release_address[64:33]
	input  wire logic [S_DATA_BITS-1:0] s_axis_tdata,
	// operation[1:0]
	input  wire logic [1:0]             s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// buffer_address[31:0], blocks_in_use[38:32], bytes_used[70:39],
	// bytes_available[102:71]
	output logic [M_DATA_BITS-1:0]      m_axis_tdata,
	// status[1:0]
	output logic [1:0]                  m_axis_tuser,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [ADDR_BITS-1:0]   cfg_data
);
	localparam int NODES = MAX_BLOCKS + 2;
	localparam int NW = $clog2(NODES + 1);
	localparam int IW = $clog2(NODES);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [NW-1:0] K_NODE = NW'(0);
	localparam logic [NW-1:0] U_NODE = NW'(MAX_BLOCKS + 1);
	localparam logic [NW-1:0] NONE = NW'(NODES);
	localparam logic [ADDR_BITS:0] HDR = (ADDR_BITS+1)'(HEADER_BYTES);
	localparam logic [ADDR_BITS:0] MRK = (ADDR_BITS+1)'(MARKER_BYTES);

	typedef enum logic [3:0] {
		S_IDLE, S_CFG_GO, S_INIT, S_A_ROUND, S_A_POP, S_A_START, S_A_STEP,
		S_A_WALK, S_A_LINK, S_R_WALK, S_R_LINK, S_P_READ, S_DONE
	} state_t;

	state_t state_q;

	// configuration and derived heap geometry
	logic [ADDR_BITS-1:0]  heap_start_q, heap_end_q, heap_bytes_q;
	logic [ALIGN_BITS-1:0] align_q, unit;
	// markers and lists
	logic [ADDR_BITS-1:0]  kstart_q, ustart_q;
	logic [NW-1:0]         klink_q, ulink_q, last_q, recycled_q, fresh_q;
	logic                  user_v_q;
	// counters
	logic [CW-1:0]         live_q;
	logic [ADDR_BITS-1:0]  used_q, free_q;
	// per-request working registers
	logic [ADDR_BITS-1:0]  req_q, raddr_q, res_addr_q;
	logic [1:0]            res_status_q;
	logic                  force_q;
	logic [NW-1:0]         slot_q, spare_next_q, n_q, link_q, prv_q, it_q, nx_q;
	logic                  slot_recycled_q, tail_q;
	logic [ADDR_BITS:0]    cur_end_q;
	// result register
	logic                  out_v_q;
	logic [ADDR_BITS-1:0]  o_addr_q, o_used_q, o_free_q;
	logic [1:0]            o_status_q;
	logic [CNT_OUT_BITS-1:0] o_live_q;

	// request fields
	logic [1:0]           in_op;
	logic [ADDR_BITS-1:0] in_size, in_raddr;
	logic                 in_force;
	logic                 s_acc, cfg_acc, out_free;

	// memory port
	logic [IW-1:0]        mem_addr;
	logic                 mem_re, mem_ws, mem_wz, mem_wl;
	logic [ADDR_BITS-1:0] mem_wd_start, mem_wd_size, rd_start, rd_size;
	logic [NW-1:0]        mem_wd_link, rd_link;

	// remainder unit
	logic                  mod_start, mod_done;
	logic [ADDR_BITS-1:0]  mod_dvd;
	logic [ALIGN_BITS-1:0] mod_rem;

	// datapath terms
	logic [ADDR_BITS:0]   hdr_sum, round_sum, e33, rd_end, plant_end;
	logic                 walk_fit, tail_fit, rel_match, spare_ok;
	logic [NW-1:0]        rel_prv, rel_it;
	logic [ADDR_BITS-1:0] init_st;

	assign in_op = s_axis_tuser;
	assign in_size = s_axis_tdata[31:0];
	assign in_force = s_axis_tdata[32];
	assign in_raddr = s_axis_tdata[64:33];

	assign cfg_ready = (state_q == S_IDLE);
	assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_v_q || m_axis_tready;

	assign unit = (align_q == '0) ? ALIGN_BITS'(1) : align_q;

	assign hdr_sum = HDR + {1'b0, in_size};
	assign round_sum = {1'b0, req_q} + (ADDR_BITS+1)'(unit - mod_rem);
	assign e33 = {1'b0, cur_end_q[ADDR_BITS-1:0]} + {1'b0, req_q};
	assign rd_end = {1'b0, rd_start} + {1'b0, rd_size};
	assign spare_ok = (recycled_q != NONE) || (fresh_q != U_NODE);
	// gap before the node just read, and room at the end of the chain
	assign walk_fit = !cur_end_q[ADDR_BITS] && !e33[ADDR_BITS] &&
	                  (e33[ADDR_BITS-1:0] <= rd_start);
	assign tail_fit = !cur_end_q[ADDR_BITS] && !e33[ADDR_BITS] &&
	                  (e33[ADDR_BITS-1:0] < heap_end_q);
	// a block end past the address space matches any address above its start
	assign rel_match = (raddr_q > rd_start) && ({1'b0, raddr_q} <= rd_end);
	assign rel_prv = (user_v_q && !(in_raddr < ustart_q)) ? U_NODE : K_NODE;
	assign rel_it = (rel_prv == U_NODE) ? ulink_q : klink_q;
	assign init_st = (mod_rem != '0) ?
	                 heap_start_q + ADDR_BITS'(unit - mod_rem) : heap_start_q;
	assign plant_end = (last_q == U_NODE) ? {1'b0, ustart_q} + MRK :
	                   {1'b0, kstart_q} + MRK;

	assign mod_start = (state_q == S_CFG_GO) ||
	                   (s_acc && in_op == OP_ALLOC && !hdr_sum[ADDR_BITS]);
	assign mod_dvd = (state_q == S_CFG_GO) ? heap_start_q : hdr_sum[ADDR_BITS-1:0];

	ffha_mod_unit u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .dividend(mod_dvd),
		.divisor(unit), .done(mod_done), .remainder(mod_rem)
	);

	ffha_node_mem #(.DEPTH(NODES), .IW(IW), .NW(NW)) u_mem (
		.clk(clk), .addr(mem_addr), .rd_en(mem_re), .wr_start(mem_ws),
		.wr_size(mem_wz), .wr_link(mem_wl), .wd_start(mem_wd_start),
		.wd_size(mem_wd_size), .wd_link(mem_wd_link), .rd_start(rd_start),
		.rd_size(rd_size), .rd_link(rd_link)
	);

	// memory port control
	always_comb begin
		mem_addr = '0;
		mem_re = 1'b0;
		mem_ws = 1'b0;
		mem_wz = 1'b0;
		mem_wl = 1'b0;
		mem_wd_start = cur_end_q[ADDR_BITS-1:0];
		mem_wd_size = req_q;
		mem_wd_link = NONE;
		case (state_q)
			S_IDLE: begin
				if (s_acc && in_op == OP_RELEASE && rel_it != NONE) begin
					mem_re = 1'b1;
					mem_addr = rel_it[IW-1:0];
				end else if (s_acc && in_op == OP_PLANT && last_q != K_NODE &&
				             last_q != U_NODE) begin
					mem_re = 1'b1;
					mem_addr = last_q[IW-1:0];
				end
			end
			S_A_ROUND: begin
				if (mod_done && recycled_q != NONE) begin
					mem_re = 1'b1;
					mem_addr = recycled_q[IW-1:0];
				end
			end
			S_A_STEP: begin
				if (link_q == NONE) begin
					if (tail_fit) begin
						mem_ws = 1'b1;
						mem_wz = 1'b1;
						mem_wl = 1'b1;
						mem_addr = slot_q[IW-1:0];
					end
				end else begin
					mem_re = 1'b1;
					mem_addr = link_q[IW-1:0];
				end
			end
			S_A_WALK: begin
				if (walk_fit) begin
					mem_ws = 1'b1;
					mem_wz = 1'b1;
					mem_wl = 1'b1;
					mem_wd_link = link_q;
					mem_addr = slot_q[IW-1:0];
				end else if (rd_link != NONE) begin
					mem_re = 1'b1;
					mem_addr = rd_link[IW-1:0];
				end
			end
			S_A_LINK: begin
				if (n_q != K_NODE && n_q != U_NODE) begin
					mem_wl = 1'b1;
					mem_wd_link = slot_q;
					mem_addr = n_q[IW-1:0];
				end
			end
			S_R_WALK: begin
				if (rel_match) begin
					mem_wl = 1'b1;
					mem_wd_link = recycled_q;
					mem_addr = it_q[IW-1:0];
				end else if (rd_link != NONE) begin
					mem_re = 1'b1;
					mem_addr = rd_link[IW-1:0];
				end
			end
			S_R_LINK: begin
				if (prv_q != K_NODE && prv_q != U_NODE) begin
					mem_wl = 1'b1;
					mem_wd_link = nx_q;
					mem_addr = prv_q[IW-1:0];
				end
			end
			default: ;
		endcase
	end

	// sequencer, state registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			heap_start_q <= HEAP_START_RST;
			heap_end_q <= HEAP_END_RST;
			align_q <= ALIGN_RST;
			heap_bytes_q <= HEAP_END_RST - HEAP_START_RST;
			kstart_q <= HEAP_START_RST;
			klink_q <= NONE;
			ulink_q <= NONE;
			ustart_q <= '0;
			user_v_q <= 1'b0;
			last_q <= K_NODE;
			recycled_q <= NONE;
			fresh_q <= NW'(1);
			live_q <= '0;
			used_q <= '0;
			free_q <= ADDR_BITS'((HEAP_END_RST - HEAP_START_RST) - MRK[ADDR_BITS-1:0]);
			out_v_q <= 1'b0;
		end else begin
			// result register: loaded from S_DONE, emptied by the sink
			if (state_q == S_DONE && out_free) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_acc) begin
						case (cfg_index)
							REG_HEAP_START: begin
								heap_start_q <= cfg_data;
								state_q <= S_CFG_GO;
							end
							REG_HEAP_END: begin
								heap_end_q <= cfg_data;
								state_q <= S_CFG_GO;
							end
							REG_ALIGN: begin
								align_q <= cfg_data[ALIGN_BITS-1:0];
								state_q <= S_CFG_GO;
							end
							default: ;
						endcase
					end else if (s_acc) begin
						res_addr_q <= '0;
						case (in_op)
							OP_ALLOC: begin
								force_q <= in_force;
								req_q <= hdr_sum[ADDR_BITS-1:0];
								if (hdr_sum[ADDR_BITS]) begin
									res_status_q <= ST_NO_SPACE;
									state_q <= S_DONE;
								end else begin
									res_status_q <= ST_OK;
									state_q <= S_A_ROUND;
								end
							end
							OP_RELEASE: begin
								raddr_q <= in_raddr;
								prv_q <= rel_prv;
								it_q <= rel_it;
								if (rel_it == NONE) begin
									res_status_q <= ST_NOT_FOUND;
									state_q <= S_DONE;
								end else begin
									res_status_q <= ST_OK;
									state_q <= S_R_WALK;
								end
							end
							OP_PLANT: begin
								res_status_q <= ST_OK;
								if (last_q == K_NODE || last_q == U_NODE) begin
									ustart_q <= plant_end[ADDR_BITS-1:0];
									ulink_q <= NONE;
									user_v_q <= 1'b1;
									last_q <= U_NODE;
									free_q <= heap_bytes_q - MRK[ADDR_BITS-1:0];
									state_q <= S_DONE;
								end else begin
									state_q <= S_P_READ;
								end
							end
							default: begin
								res_status_q <= ST_OK;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_CFG_GO: state_q <= S_INIT;
				S_INIT: begin
					// rebuild: drop all blocks, markers back to defaults
					if (mod_done) begin
						kstart_q <= init_st;
						heap_bytes_q <= heap_end_q - init_st;
						free_q <= heap_end_q - init_st - MRK[ADDR_BITS-1:0];
						klink_q <= NONE;
						ulink_q <= NONE;
						user_v_q <= 1'b0;
						last_q <= K_NODE;
						recycled_q <= NONE;
						fresh_q <= NW'(1);
						live_q <= '0;
						used_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_A_ROUND: begin
					if (mod_done) begin
						if (mod_rem != '0) req_q <= round_sum[ADDR_BITS-1:0];
						if ((mod_rem != '0 && round_sum[ADDR_BITS]) || !spare_ok) begin
							res_status_q <= ST_NO_SPACE;
							state_q <= S_DONE;
						end else if (recycled_q != NONE) begin
							slot_q <= recycled_q;
							slot_recycled_q <= 1'b1;
							state_q <= S_A_POP;
						end else begin
							slot_q <= fresh_q;
							slot_recycled_q <= 1'b0;
							state_q <= S_A_START;
						end
					end
				end
				S_A_POP: begin
					spare_next_q <= rd_link;
					state_q <= S_A_START;
				end
				S_A_START: begin
					if (force_q || !user_v_q) begin
						n_q <= K_NODE;
						cur_end_q <= {1'b0, kstart_q} + MRK;
						link_q <= klink_q;
					end else begin
						n_q <= U_NODE;
						cur_end_q <= {1'b0, ustart_q} + MRK;
						link_q <= ulink_q;
					end
					state_q <= S_A_STEP;
				end
				S_A_STEP: begin
					if (link_q == NONE) begin
						if (tail_fit) begin
							tail_q <= 1'b1;
							state_q <= S_A_LINK;
						end else begin
							res_status_q <= ST_NO_SPACE;
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_A_WALK;
					end
				end
				S_A_WALK: begin
					if (walk_fit) begin
						tail_q <= 1'b0;
						state_q <= S_A_LINK;
					end else begin
						n_q <= link_q;
						cur_end_q <= rd_end;
						link_q <= rd_link;
						if (rd_link == NONE) state_q <= S_A_STEP;
					end
				end
				S_A_LINK: begin
					if (n_q == K_NODE) klink_q <= slot_q;
					else if (n_q == U_NODE) ulink_q <= slot_q;
					if (slot_recycled_q) recycled_q <= spare_next_q;
					else fresh_q <= fresh_q + 1'b1;
					if (tail_q) last_q <= slot_q;
					live_q <= live_q + 1'b1;
					used_q <= used_q + req_q;
					free_q <= free_q - req_q;
					res_addr_q <= cur_end_q[ADDR_BITS-1:0] + HDR[ADDR_BITS-1:0];
					state_q <= S_DONE;
				end
				S_R_WALK: begin
					if (rel_match) begin
						nx_q <= rd_link;
						live_q <= live_q - 1'b1;
						used_q <= used_q - rd_size;
						free_q <= free_q + rd_size;
						recycled_q <= it_q;
						if (rd_link == NONE) last_q <= prv_q;
						state_q <= S_R_LINK;
					end else if (rd_link == NONE) begin
						res_status_q <= ST_NOT_FOUND;
						state_q <= S_DONE;
					end else begin
						prv_q <= it_q;
						it_q <= rd_link;
					end
				end
				S_R_LINK: begin
					if (prv_q == K_NODE) klink_q <= nx_q;
					else if (prv_q == U_NODE) ulink_q <= nx_q;
					state_q <= S_DONE;
				end
				S_P_READ: begin
					ustart_q <= rd_end[ADDR_BITS-1:0];
					ulink_q <= NONE;
					user_v_q <= 1'b1;
					last_q <= U_NODE;
					free_q <= heap_bytes_q - MRK[ADDR_BITS-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						o_addr_q <= res_addr_q;
						o_status_q <= res_status_q;
						o_live_q <= CNT_OUT_BITS'(live_q);
						o_used_q <= used_q;
						o_free_q <= free_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser = o_status_q;
	assign m_axis_tdata = {1'b0, o_free_q, o_used_q, o_live_q, o_addr_q};
endmodule
`default_nettype wire

/* rtl/ffha_mod_unit.sv */
// Bit-serial remainder unit: dividend modulo a 13-bit unit, one bit per cycle.
// Depends on ffha_pkg.
`default_nettype none
module ffha_mod_unit import ffha_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [ADDR_BITS-1:0]  dividend,
	input  wire logic [ALIGN_BITS-1:0] divisor,
	output logic                       done,
	output logic [ALIGN_BITS-1:0]      remainder
);
	localparam int CNT_W = $clog2(ADDR_BITS);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ADDR_BITS-1:0]  dvd_q;
	logic [ALIGN_BITS-1:0] rem_q;
	logic [ALIGN_BITS-1:0] div_q;
	logic [ALIGN_BITS:0]   trial;
	logic                  last_bit;

	assign trial = {rem_q, dvd_q[ADDR_BITS-1]};
	assign last_bit = (cnt_q == CNT_W'(ADDR_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && last_bit;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_bit)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ADDR_BITS-2:0], 1'b0};
			if (trial >= {1'b0, div_q})
				rem_q <= ALIGN_BITS'(trial - {1'b0, div_q});
			else
				rem_q <= trial[ALIGN_BITS-1:0];
		end
	end

	assign done = done_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

/* rtl/ffha_node_mem.sv */
// Node table: start, size and link arrays on one shared port, registered read.
// Depends on ffha_pkg.
`default_nettype none
module ffha_node_mem import ffha_pkg::*; #(
	parameter int DEPTH = MAX_BLOCKS_DEF + 2,
	parameter int IW = $clog2(MAX_BLOCKS_DEF + 2),
	parameter int NW = $clog2(MAX_BLOCKS_DEF + 3)
) (
	input  wire logic                 clk,
	input  wire logic [IW-1:0]        addr,
	input  wire logic                 rd_en,
	input  wire logic                 wr_start,
	input  wire logic                 wr_size,
	input  wire logic                 wr_link,
	input  wire logic [ADDR_BITS-1:0] wd_start,
	input  wire logic [ADDR_BITS-1:0] wd_size,
	input  wire logic [NW-1:0]        wd_link,
	output logic [ADDR_BITS-1:0]      rd_start,
	output logic [ADDR_BITS-1:0]      rd_size,
	output logic [NW-1:0]             rd_link
);
	logic [ADDR_BITS-1:0] start_mem [DEPTH];
	logic [ADDR_BITS-1:0] size_mem [DEPTH];
	logic [NW-1:0]        link_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_start) start_mem[addr] <= wd_start;
		if (wr_size)  size_mem[addr] <= wd_size;
		if (wr_link)  link_mem[addr] <= wd_link;
		if (rd_en) begin
			rd_start <= start_mem[addr];
			rd_size  <= size_mem[addr];
			rd_link  <= link_mem[addr];
		end
	end
endmodule
`default_nettype wire
